>>> rtl/utf8p_pkg.sv
// ---------------------------------------------------------------------------
// utf8p_pkg
// Shared types and constants for the UTF-8 decoder with position tracking.
// ---------------------------------------------------------------------------
package utf8p_pkg;

    localparam int CP_W  = 21;
    localparam int POS_W = 32;
    localparam int ST_W  = 2;

    localparam logic [ST_W-1:0] ST_VALID    = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_CONT = 2'd2;

    localparam logic [CP_W-1:0]  CP_NEWLINE = 21'h00000A;
    localparam logic [CP_W-1:0]  CP_BOM     = 21'h00FEFF;
    localparam logic [POS_W-1:0] POS_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [POS_W-1:0] line_number;
        logic [POS_W-1:0] column_number;
        logic [ST_W-1:0]  status;
    } result_t;

endpackage

>>> rtl/utf8p_in_stage.sv
// ---------------------------------------------------------------------------
// utf8p_in_stage
// Input byte register; hands the core one beat per cycle while room is set.
// ---------------------------------------------------------------------------
module utf8p_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] raw_byte,
    input  logic       room,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       advance;
    logic       accept;

    assign advance    = valid_reg && room;
    assign in_stall   = valid_reg && !room;
    assign accept     = in_valid && !in_stall;
    assign byte_valid = advance;
    assign byte_data  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= raw_byte;
        end
    end

endmodule

>>> rtl/utf8p_core.sv
// ---------------------------------------------------------------------------
// utf8p_core
// Character assembly, error detection, row/column tracking and mark drop.
// ---------------------------------------------------------------------------
module utf8p_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                byte_valid,
    input  logic [7:0]          byte_data,
    output logic                res_valid,
    output utf8p_pkg::result_t  res
);
    import utf8p_pkg::*;

    logic [CP_W-1:0]  partial_reg;
    logic [CP_W-1:0]  partial_next;
    logic [1:0]       remain_reg;
    logic [1:0]       remain_next;
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] row_next;
    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] col_next;
    logic             start_reg;
    logic             start_next;
    logic             drop_bom_reg;

    logic             emit;
    logic [CP_W-1:0]  fin_cp;
    logic [ST_W-1:0]  fin_st;
    logic [CP_W-1:0]  shifted;
    logic             is_newline;
    logic             is_lead_bom;

    assign shifted = {partial_reg[CP_W-7:0], byte_data[5:0]};

    always_comb
    begin
        partial_next = partial_reg;
        remain_next  = remain_reg;
        emit         = 1'b0;
        fin_cp       = partial_reg;
        fin_st       = ST_VALID;
        if (byte_valid)
        begin
            if (remain_reg != 2'd0)
            begin
                if (byte_data[7:6] != 2'b10)
                begin
                    emit   = 1'b1;
                    fin_cp = partial_reg;
                    fin_st = ST_BAD_CONT;
                end
                else
                begin
                    remain_next  = remain_reg - 2'd1;
                    partial_next = shifted;
                    if (remain_reg == 2'd1)
                    begin
                        emit   = 1'b1;
                        fin_cp = shifted;
                    end
                end
            end
            else
            begin
                priority if (byte_data[7] == 1'b0)
                begin
                    emit   = 1'b1;
                    fin_cp = {{(CP_W-8){1'b0}}, byte_data};
                end
                else if (byte_data[7:5] == 3'b110)
                begin
                    partial_next = {{(CP_W-5){1'b0}}, byte_data[4:0]};
                    remain_next  = 2'd1;
                end
                else if (byte_data[7:4] == 4'b1110)
                begin
                    partial_next = {{(CP_W-4){1'b0}}, byte_data[3:0]};
                    remain_next  = 2'd2;
                end
                else if (byte_data[7:3] == 5'b11110)
                begin
                    partial_next = {{(CP_W-3){1'b0}}, byte_data[2:0]};
                    remain_next  = 2'd3;
                end
                else
                begin
                    emit   = 1'b1;
                    fin_cp = {{(CP_W-8){1'b0}}, byte_data};
                    fin_st = ST_BAD_LEAD;
                end
            end
        end
    end

    assign is_newline  = (fin_st == ST_VALID) && (fin_cp == CP_NEWLINE);
    assign is_lead_bom = start_reg && drop_bom_reg && (fin_st == ST_VALID)
                         && (fin_cp == CP_BOM);

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        start_next = start_reg;
        if (emit)
        begin
            start_next = 1'b0;
            if (is_newline)
            begin
                row_next = (row_reg == POS_MAX) ? row_reg : row_reg + 32'd1;
                col_next = '0;
            end
            else
            begin
                col_next = (col_reg == POS_MAX) ? col_reg : col_reg + 32'd1;
            end
        end
    end

    assign res_valid         = emit && !is_lead_bom;
    assign res.code_point    = fin_cp;
    assign res.line_number   = row_next;
    assign res.column_number = col_next;
    assign res.status        = fin_st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg  <= '0;
            remain_reg   <= 2'd0;
            row_reg      <= 32'd1;
            col_reg      <= '0;
            start_reg    <= 1'b1;
            drop_bom_reg <= 1'b1;
        end
        else
        begin
            partial_reg <= emit ? '0 : partial_next;
            remain_reg  <= emit ? 2'd0 : remain_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            start_reg   <= start_next;
            if (cfg_we)
            begin
                drop_bom_reg <= cfg_wdata;
            end
        end
    end

    a_row_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg != '0)
        else $error("row counter reached zero");

    a_bad_lead_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && fin_st == ST_BAD_LEAD) |-> (remain_reg == 2'd0))
        else $error("bad lead reported inside a character");

    a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (remain_reg == 2'd0 && !start_reg))
        else $error("character not closed after result");

    a_newline_col: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && is_newline) |=> (col_reg == '0))
        else $error("column not cleared after newline");

endmodule

>>> rtl/utf8p_out_fifo.sv
// ---------------------------------------------------------------------------
// utf8p_out_fifo
// Two-entry result buffer; the head entry drives the output beat.
// ---------------------------------------------------------------------------
module utf8p_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  utf8p_pkg::result_t push_data,
    output logic               room,
    output logic               out_valid,
    input  logic               out_stall,
    output utf8p_pkg::result_t head
);
    import utf8p_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign room      = (count_reg != 2'd2);
    assign pop       = out_valid && !out_stall;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/utf8_decoder_with_position_unit.sv
// ---------------------------------------------------------------------------
// utf8_decoder_with_position_unit
// Takes one byte a beat, takes apart UTF-8 and gives code point, row, column
// and status for each finished character or error. A byte is taken every
// cycle while the input does not stall; it is held in the input register and
// then decoded into a two-entry result buffer. The input stalls only while
// that buffer is full. A leading U+FEFF is dropped when drop_bom_reg (core),
// written through cfg_we/cfg_wdata (reset 1), is set.
// ---------------------------------------------------------------------------
module utf8_decoder_with_position_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  raw_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] code_point,
    output logic [31:0] line_number,
    output logic [31:0] column_number,
    output logic [1:0]  status
);
    import utf8p_pkg::*;

    logic       room;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       res_valid;
    result_t    res;
    result_t    head;

    utf8p_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_byte   (raw_byte),
        .room       (room),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    utf8p_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .res_valid  (res_valid),
        .res        (res)
    );

    utf8p_out_fifo u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .room       (room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .head       (head)
    );

    assign code_point    = head.code_point;
    assign line_number   = head.line_number;
    assign column_number = head.column_number;
    assign status        = head.status;

endmodule

>>> bench/utf8_decoder_with_position_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_decoder_with_position_unit_tb
// Feeds the decoder a byte stream built from well-formed UTF-8 characters of
// every length, newlines, stray and truncated sequences and random noise. It
// decodes the same bytes in a behavioral model of its own and checks every
// code point, row, column and status that comes out, in order. Bursty input
// and runs of receiver stall are used. The byte-order-mark setting is
// switched between phases.
// ---------------------------------------------------------------------------
module utf8_decoder_with_position_unit_tb;
    import utf8p_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 320;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         raw_byte;
    logic               out_valid;
    logic               out_stall;
    logic [CP_W-1:0]    code_point;
    logic [POS_W-1:0]   line_number;
    logic [POS_W-1:0]   column_number;
    logic [ST_W-1:0]    status;

    // decoder model state
    logic [CP_W-1:0]    acc_value;
    logic [1:0]         conts_left;
    logic [POS_W-1:0]   cur_row;
    logic [POS_W-1:0]   cur_col;
    logic               first_char;
    logic               skip_bom;

    result_t            expected_chars[$];
    logic [7:0]         tx_bytes[$];
    int                 bytes_pushed;
    int                 error_count;
    int                 cycle_count;
    int                 burst_left;
    int                 gap_left;
    int                 stall_run;
    int                 stall_pct;
    logic               gaps_on;
    logic               beat_taken;

    utf8_decoder_with_position_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .raw_byte      (raw_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .code_point    (code_point),
        .line_number   (line_number),
        .column_number (column_number),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void close_char(input logic [CP_W-1:0] cp, input logic [ST_W-1:0] st);
        result_t r;
        logic    was_first;
        was_first = first_char;
        if (st == ST_VALID && cp == CP_NEWLINE)
        begin
            if (cur_row != POS_MAX)
                cur_row = cur_row + 1;
            cur_col = '0;
        end
        else if (cur_col != POS_MAX)
        begin
            cur_col = cur_col + 1;
        end
        first_char = 1'b0;
        acc_value  = '0;
        conts_left = '0;
        if (!(was_first && skip_bom && st == ST_VALID && cp == CP_BOM))
        begin
            r.code_point    = cp;
            r.line_number   = cur_row;
            r.column_number = cur_col;
            r.status        = st;
            expected_chars.push_back(r);
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        if (conts_left != 0)
        begin
            if (b[7:6] != 2'b10)
                close_char(acc_value, ST_BAD_CONT);
            else
            begin
                acc_value  = {acc_value[CP_W-7:0], b[5:0]};
                conts_left = conts_left - 2'd1;
                if (conts_left == 0)
                    close_char(acc_value, ST_VALID);
            end
        end
        else if (!b[7])
            close_char({14'd0, b[6:0]}, ST_VALID);
        else if (b[7:5] == 3'b110)
        begin
            acc_value  = {16'd0, b[4:0]};
            conts_left = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            acc_value  = {17'd0, b[3:0]};
            conts_left = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            acc_value  = {18'd0, b[2:0]};
            conts_left = 2'd3;
        end
        else
            close_char({13'd0, b}, ST_BAD_LEAD);
    endfunction

    // input driver: bursts of beats with random gaps between them
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || beat_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (tx_bytes.size() != 0)
            begin
                raw_byte <= tx_bytes.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= gaps_on ? $urandom_range(0, 6) : 0;
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall: runs of constant level
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_run == 0)
        begin
            stall_run <= $urandom_range(1, 12);
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
        else
            stall_run <= stall_run - 1;
    end

    // monitor and checker
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected beat: cp %h row %0d col %0d status %0d",
                                 code_point, line_number, column_number, status);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (code_point !== want.code_point || line_number !== want.line_number ||
                        column_number !== want.column_number || status !== want.status)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("mismatch: got cp %h row %0d col %0d status %0d, %s",
                                     code_point, line_number, column_number, status,
                                     $sformatf("want cp %h row %0d col %0d status %0d",
                                               want.code_point, want.line_number,
                                               want.column_number, want.status));
                    end
                end
            end
            beat_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                decode_byte(raw_byte);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic put_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        bytes_pushed++;
    endtask

    // encode cp in len bytes, keep only the first n of them
    task automatic put_char(input logic [CP_W-1:0] cp, input int len, input int n);
        logic [7:0] enc[4];
        int         k;
        case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (k = 0; k < n; k++)
            put_byte(enc[k]);
    endtask

    task automatic add_random_seq();
        int              pick;
        int              len;
        logic [CP_W-1:0] cp;
        logic [7:0]      b;
        pick = $urandom_range(0, 99);
        len  = $urandom_range(1, 4);
        cp   = CP_W'($urandom);
        b    = 8'($urandom);
        if (pick < 8)
            put_byte(8'h0A);
        else if (pick < 78)
            put_char(cp, len, len);
        else if (pick < 90)
        begin
            // truncated character ended by a byte that is not a continuation
            len = $urandom_range(2, 4);
            put_char(cp, len, $urandom_range(1, len - 1));
            if (b[7:6] == 2'b10)
                b[6] = 1'b1;
            put_byte(b);
        end
        else
            put_byte(b);
    endtask

    task automatic wait_idle();
        while (tx_bytes.size() != 0 || in_valid || expected_chars.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_drop_bom(input logic v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        skip_bom  = v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int phase;
        int mark;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        in_valid     = 1'b0;
        raw_byte     = 8'h00;
        out_stall    = 1'b0;
        acc_value    = '0;
        conts_left   = '0;
        cur_row      = 1;
        cur_col      = '0;
        first_char   = 1'b1;
        skip_bom     = 1'b1;
        bytes_pushed = 0;
        error_count  = 0;
        cycle_count  = 0;
        burst_left   = 0;
        gap_left     = 0;
        stall_run    = 0;
        stall_pct    = 30;
        gaps_on      = 1'b1;
        beat_taken   = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_drop_bom(1'b1);
        // leading mark is dropped, a later one is not
        put_char(CP_BOM, 3, 3);
        put_byte(8'h00);
        put_byte(8'h7F);
        put_byte(8'h0A);
        put_char(21'h000080, 2, 2);
        put_char(21'h0007FF, 2, 2);
        put_char(21'h00FFFF, 3, 3);
        put_char(21'h010000, 4, 4);
        put_char(21'h1FFFFF, 4, 4);
        put_char(CP_BOM, 3, 3);
        put_byte(8'h80);
        put_byte(8'hBF);
        put_byte(8'hF8);
        put_byte(8'hFF);
        // bad continuation swallows the offending byte
        put_byte(8'hC3);
        put_byte(8'h41);
        // error whose partial value is 0x0A keeps the row
        put_byte(8'hE0);
        put_byte(8'h8A);
        put_byte(8'h41);
        // overlong newline
        put_byte(8'hC0);
        put_byte(8'h8A);
        put_byte(8'hF4);
        put_byte(8'h90);
        put_byte(8'hC3);
        put_byte(8'hA9);

        for (phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            write_drop_bom(phase[0]);
            case (phase)
                0:
                begin
                    stall_pct = 0;
                    gaps_on   = 1'b0;
                end
                1:
                begin
                    stall_pct = 50;
                    gaps_on   = 1'b1;
                end
                2:
                begin
                    stall_pct = 85;
                    gaps_on   = 1'b1;
                end
                default:
                begin
                    stall_pct = 20;
                    gaps_on   = 1'b1;
                end
            endcase
            mark = bytes_pushed;
            while (bytes_pushed - mark < PHASE_BYTES)
                add_random_seq();
        end

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
rtl/utf8p_pkg.sv
rtl/utf8p_in_stage.sv
rtl/utf8p_core.sv
rtl/utf8p_out_fifo.sv
rtl/utf8_decoder_with_position_unit.sv
bench/utf8_decoder_with_position_unit_tb.sv
